FILE: src/rsfr_pkg.sv
// shared types, constants and a helper function for the serial frame receiver
`timescale 1ns / 1ps

package rsfr_pkg;

   // frame buffer size and derived widths
   localparam int FRAME_MAX   = 64;
   localparam int CNT_W       = $clog2(FRAME_MAX + 1);
   localparam int FRAME_LEN_W = 7;
   localparam int BYTE_W      = 8;
   localparam int FREQ_W      = 32;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // delimiter modes
   localparam logic [1:0] DELIM_SEMI   = 2'd0;
   localparam logic [1:0] DELIM_EOM    = 2'd1;
   localparam logic [1:0] DELIM_ZERO   = 2'd2;
   localparam logic [1:0] DELIM_EITHER = 2'd3;

   // byte codes
   localparam logic [BYTE_W-1:0] BYTE_SEMI     = 8'h3b;
   localparam logic [BYTE_W-1:0] BYTE_EOM      = 8'hfd;
   localparam logic [BYTE_W-1:0] BYTE_PREAMBLE = 8'hfe;
   localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
   localparam logic [3:0]        NIBBLE_MASK   = 4'hf;

   // frame positions of interest
   localparam int POS_PREAMBLE0 = 0;
   localparam int POS_PREAMBLE1 = 1;
   localparam int POS_SUBCMD    = 4;
   localparam int POS_BCD_FIRST = 5;
   localparam int POS_BCD_LAST  = 9;
   localparam int CIV_FREQ_LEN  = 11;
   localparam int DIGIT_IDX_W   = 3;

   // csr register indexes
   localparam logic REG_DELIM_MODE = 1'b0;
   localparam logic REG_CIV_DECODE = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0]      rx_byte;
      logic                   frame_end;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic                   len_eleven;
      logic                   hdr_bad;
      logic                   digit;
      logic [FREQ_W-1:0]      term;
   } entry_type;

   // weight of each bcd byte, 100x the one before
   function automatic logic [FREQ_W-1:0] bcd_weight(input logic [DIGIT_IDX_W-1:0] idx);
      logic [FREQ_W-1:0] w;
      begin
         case (idx)
            3'd0: w = 32'd1;
            3'd1: w = 32'd100;
            3'd2: w = 32'd10000;
            3'd3: w = 32'd1000000;
            3'd4: w = 32'd100000000;
            default: w = 32'd0;
         endcase
         return w;
      end
   endfunction

endpackage

FILE: src/rig_serial_frame_receiver.sv
// top level of the serial frame receiver: csr registers and front/queue/back
`timescale 1ns / 1ps

// Takes one received byte per request and returns one result per byte: the
// byte echoed, a frame-end mark with the frame length, and the held CI-V
// frequency. A frame closes on the delimiter picked by delim_mode or at
// FRAME_MAX bytes. Sustained rate is one byte per clock while rsp_ready is
// held high; an accepted request is written into the two-entry queue
// between the classifying front end and the accumulate-and-register back
// end, which moves it into the output register as it pops it. Registers:
// delim_mode at byte address 0, civ_decode at address 4; write them only
// while no request is in flight.
module rig_serial_frame_receiver
   import rsfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_frame_end,
   output logic [FRAME_LEN_W-1:0] rsp_frame_length,
   output logic                   rsp_freq_update,
   output logic [FREQ_W-1:0]      rsp_frequency,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [1:0] delim_mode_ff, delim_mode_in;
   logic       civ_decode_ff, civ_decode_in;
   logic       csr_write;
   logic       csr_index;
   logic       push, push_ready;
   entry_type  push_entry;
   logic       pop, pop_valid;
   entry_type  pop_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      delim_mode_in = delim_mode_ff;
      civ_decode_in = civ_decode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DELIM_MODE: delim_mode_in = pwdata[1:0];
            REG_CIV_DECODE: civ_decode_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DELIM_MODE: prdata = {30'b0, delim_mode_ff};
         REG_CIV_DECODE: prdata = {31'b0, civ_decode_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_mode_ff <= DELIM_EOM;
         civ_decode_ff <= 1'b1;
      end else begin
         delim_mode_ff <= delim_mode_in;
         civ_decode_ff <= civ_decode_in;
      end
   end

   rsfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .delim_mode  (delim_mode_ff),
      .push_ready  (push_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   rsfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   rsfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .civ_decode       (civ_decode_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_length (rsp_frame_length),
      .rsp_freq_update  (rsp_freq_update),
      .rsp_frequency    (rsp_frequency)
   );

endmodule

FILE: src/rsfr_front.sv
// front end: takes requests, tracks frame position and classifies each byte
`timescale 1ns / 1ps

module rsfr_front
   import rsfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [1:0]        delim_mode,
   input  logic              push_ready,
   output logic              push,
   output entry_type         push_entry
);

   logic [CNT_W-1:0]       byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]       len;
   logic                   is_delim;
   logic                   frame_end;
   logic                   hdr_bad;
   logic                   digit;
   logic [DIGIT_IDX_W-1:0] digit_idx;
   logic [BYTE_W-1:0]      digit_val;
   logic [3:0]             lo_nib, hi_nib;
   logic [FREQ_W-1:0]      term;

   assign req_ready = push_ready;
   assign push      = req_valid && push_ready;

   always_comb begin
      case (delim_mode)
         DELIM_SEMI:   is_delim = (req_rx_byte == BYTE_SEMI);
         DELIM_EOM:    is_delim = (req_rx_byte == BYTE_EOM);
         DELIM_ZERO:   is_delim = (req_rx_byte == BYTE_ZERO);
         DELIM_EITHER: is_delim = (req_rx_byte == BYTE_SEMI) || (req_rx_byte == BYTE_EOM);
         default:      is_delim = 1'b0;
      endcase
   end

   assign len       = byte_count_ff + CNT_W'(1);
   assign frame_end = is_delim || (len >= CNT_W'(FRAME_MAX));

   assign hdr_bad =
      (((byte_count_ff == CNT_W'(POS_PREAMBLE0)) || (byte_count_ff == CNT_W'(POS_PREAMBLE1)))
         && (req_rx_byte != BYTE_PREAMBLE))
      || ((byte_count_ff == CNT_W'(POS_SUBCMD)) && (req_rx_byte != BYTE_ZERO));

   assign digit = (byte_count_ff >= CNT_W'(POS_BCD_FIRST))
               && (byte_count_ff <= CNT_W'(POS_BCD_LAST));
   assign digit_idx = DIGIT_IDX_W'(byte_count_ff - CNT_W'(POS_BCD_FIRST));

   // packed bcd byte to its value, digits above nine weighted as they stand
   assign lo_nib    = req_rx_byte[3:0] & NIBBLE_MASK;
   assign hi_nib    = req_rx_byte[7:4] & NIBBLE_MASK;
   assign digit_val = BYTE_W'(lo_nib) + (BYTE_W'(hi_nib) << 3) + (BYTE_W'(hi_nib) << 1);
   assign term      = FREQ_W'(FREQ_W'(digit_val) * bcd_weight(digit_idx));

   always_comb begin
      push_entry.rx_byte      = req_rx_byte;
      push_entry.frame_end    = frame_end;
      push_entry.frame_length = frame_end ? FRAME_LEN_W'(len) : '0;
      push_entry.len_eleven   = (len == CNT_W'(CIV_FREQ_LEN));
      push_entry.hdr_bad      = hdr_bad;
      push_entry.digit        = digit;
      push_entry.term         = term;
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      if (push) begin
         byte_count_in = frame_end ? '0 : len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

FILE: src/rsfr_queue.sv
// short request queue between the front end and the back end
`timescale 1ns / 1ps

module rsfr_queue
   import rsfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
`endif

endmodule

FILE: src/rsfr_back.sv
// back end: bcd accumulation, header check, frequency hold and output register
`timescale 1ns / 1ps

module rsfr_back
   import rsfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  entry_type              pop_entry,
   output logic                   pop,
   input  logic                   civ_decode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_frame_end,
   output logic [FRAME_LEN_W-1:0] rsp_frame_length,
   output logic                   rsp_freq_update,
   output logic [FREQ_W-1:0]      rsp_frequency
);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   frame_end_ff;
   logic [FRAME_LEN_W-1:0] frame_length_ff;
   logic                   freq_update_ff;
   logic [FREQ_W-1:0]      accum_ff, accum_in;
   logic                   hdr_ff, hdr_in;
   logic [FREQ_W-1:0]      held_ff, held_in;
   logic [FREQ_W-1:0]      accum_sum;
   logic                   hdr_next;
   logic                   upd;

   assign pop = pop_valid && (!rsp_valid_ff || rsp_ready);

   assign accum_sum = accum_ff + (pop_entry.digit ? pop_entry.term : '0);
   assign hdr_next  = hdr_ff && !pop_entry.hdr_bad;
   assign upd       = pop_entry.frame_end && civ_decode && pop_entry.len_eleven && hdr_next;

   always_comb begin
      accum_in     = accum_ff;
      hdr_in       = hdr_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (pop_entry.frame_end) begin
            accum_in = '0;
            hdr_in   = 1'b1;
         end else begin
            accum_in = accum_sum;
            hdr_in   = hdr_next;
         end
         if (upd) begin
            held_in = accum_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         accum_ff     <= '0;
         hdr_ff       <= 1'b1;
         held_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         accum_ff     <= accum_in;
         hdr_ff       <= hdr_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff     <= pop_entry.rx_byte;
         frame_end_ff    <= pop_entry.frame_end;
         frame_length_ff <= pop_entry.frame_length;
         freq_update_ff  <= upd;
      end
   end

   // held frequency only moves together with a new result
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_frame_length = frame_length_ff;
   assign rsp_freq_update  = freq_update_ff;
   assign rsp_frequency    = held_ff;

`ifndef SYNTHESIS
   a_update_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && freq_update_ff |-> frame_end_ff)
      else $error("frequency update without frame end");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.frame_end |=> (accum_ff == '0) && hdr_ff)
      else $error("frame state not cleared after frame end");

   a_held_moves_on_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(held_ff) |-> $past(pop && upd))
      else $error("held frequency changed without update");
`endif

endmodule
